>>> hw/rtl/hds_pkg.sv
// Shared types and constants for the heat diffusion stencil.
// No dependencies; every other file imports this package.
package hds_pkg;

	// Frame limits and derived widths
	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int RowW      = $clog2(MaxHeight);
	localparam int DimW      = 11;
	localparam int PixW      = 8;
	localparam int PosW      = 10;

	// Result queue
	localparam int QDepth = 8;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);
	localparam int MaxRes = 3;

	// Configuration port
	localparam int AddrW = 3;
	localparam int DataW = 32;
	localparam logic RegWidth  = 1'b0;
	localparam logic RegHeight = 1'b1;

	// One result request
	typedef struct packed {
		logic [PixW-1:0] pixel_out;
		logic [PosW-1:0] out_row;
		logic [PosW-1:0] out_col;
		logic            run_last;
	} res_t;

	// Up to three results produced by one input pixel, in output order
	typedef struct packed {
		logic [1:0]             count;
		res_t [MaxRes-1:0]      slot;
	} res_bundle_t;

	// Frame geometry and restart from the register block
	typedef struct packed {
		logic [ColW-1:0] last_col;
		logic [RowW-1:0] last_row;
		logic            restart;
	} cfg_ctl_t;

endpackage

>>> hw/rtl/hds_if.sv
// Stream channel interfaces: pixel requests in, result requests out.
// Depends on hds_pkg for field widths.
interface hds_pix_if import hds_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PixW-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
	modport mon (input valid, input pixel_in, input ready);
endinterface

interface hds_res_if import hds_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PixW-1:0] pixel_out;
	logic [PosW-1:0] out_row;
	logic [PosW-1:0] out_col;
	logic            run_last;

	modport source (output valid, output pixel_out, output out_row, output out_col,
		output run_last, input ready);
	modport sink (input valid, input pixel_out, input out_row, input out_col,
		input run_last, output ready);
	modport mon (input valid, input pixel_out, input out_row, input out_col,
		input run_last, input ready);
endinterface

>>> hw/rtl/hds_cfg.sv
// APB register block: image width and height, effective frame limits.
// Depends on hds_pkg.
module hds_cfg import hds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_ctl_t         ctl
);

	logic [DimW-1:0] width_q;
	logic [DimW-1:0] height_q;
	logic            wr_en;
	logic [DimW-1:0] eff_w;
	logic [DimW-1:0] eff_h;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DimW'(MaxWidth);
			height_q <= DimW'(MaxHeight);
		end else if (wr_en) begin
			if (paddr[2] == RegWidth) begin
				width_q <= pwdata[DimW-1:0];
			end else begin
				height_q <= pwdata[DimW-1:0];
			end
		end
	end

	// Read back the raw values
	always_comb begin
		prdata = '0;
		if (paddr[2] == RegWidth) begin
			prdata[DimW-1:0] = width_q;
		end else begin
			prdata[DimW-1:0] = height_q;
		end
	end

	// Limit to 2..max
	always_comb begin
		if (width_q < DimW'(2)) eff_w = DimW'(2);
		else if (width_q > DimW'(MaxWidth)) eff_w = DimW'(MaxWidth);
		else eff_w = width_q;
		if (height_q < DimW'(2)) eff_h = DimW'(2);
		else if (height_q > DimW'(MaxHeight)) eff_h = DimW'(MaxHeight);
		else eff_h = height_q;
	end

	assign ctl.last_col = ColW'(eff_w - DimW'(1));
	assign ctl.last_row = RowW'(eff_h - DimW'(1));
	assign ctl.restart  = wr_en;

endmodule

>>> hw/rtl/hds_stencil.sv
// Stencil datapath: raster counters, two line memories and the
// four-neighbor diffusion stage. Depends on hds_pkg.
module hds_stencil import hds_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_ctl_t        ctl,
	input  logic            accept,
	input  logic [PixW-1:0] pixel_in,
	output res_bundle_t     bundle
);

	// Line memories: line1 holds the previous row, line2 the one before it
	logic [PixW-1:0] line1_mem [MaxWidth];
	logic [PixW-1:0] line2_mem [MaxWidth];
	logic [PixW-1:0] rd1_q;
	logic [PixW-1:0] rd2_q;

	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic [ColW-1:0] next_col;
	logic            at_last_col;
	logic            at_last_row;

	logic [PixW-1:0] prev_q;
	logic [PixW-1:0] rec0_q;
	logic [PixW-1:0] rec1_q;

	// Stage 1 registers
	logic            valid_s1;
	logic [PixW-1:0] ctr_s1;
	logic [PixW-1:0] north_s1;
	logic [PixW-1:0] west_s1;
	logic [PixW-1:0] px_s1;
	logic [PixW-1:0] rec0_s1;
	logic [PixW-1:0] rec1_s1;
	logic [RowW-1:0] row_s1;
	logic [ColW-1:0] col_s1;
	logic            has_up_s1;
	logic            has_w_s1;
	logic            has_ww_s1;
	logic            has_e_s1;
	logic            last_row_s1;
	logic            last_col_s1;

	logic [PixW-1:0] east;
	logic [PixW-1:0] a_w;
	logic [PixW-1:0] a_e;
	logic [PixW-1:0] b_w;
	res_t            res_a;
	res_t            res_b;
	res_t            res_c;
	logic            do_b;
	logic            do_c;

	// c + trunc((n+s+e+w-4c)/4), clamped to the pixel range
	function automatic logic [PixW-1:0] diffuse(input logic [PixW-1:0] c,
		input logic [PixW-1:0] n, input logic [PixW-1:0] s,
		input logic [PixW-1:0] e, input logic [PixW-1:0] w);
		logic [11:0]        sum;
		logic signed [11:0] d;
		logic signed [11:0] q;
		logic signed [11:0] v;
		sum = 12'(n) + 12'(s) + 12'(e) + 12'(w);
		d   = $signed(sum - {2'b00, c, 2'b00});
		q   = (d < 0) ? ((d + 12'sd3) >>> 2) : (d >>> 2);
		v   = $signed(12'(c)) + q;
		if (v < 0) return '0;
		if (v > 12'sd255) return '1;
		return v[PixW-1:0];
	endfunction

	assign at_last_col = (col_q == ctl.last_col);
	assign at_last_row = (row_q == ctl.last_row);
	assign next_col    = at_last_col ? '0 : col_q + ColW'(1);

	// Raster position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= next_col;
			if (at_last_col) begin
				row_q <= at_last_row ? '0 : row_q + RowW'(1);
			end
		end
	end

	// Line memories: write the current column, prefetch the next one
	always_ff @(posedge clk) begin
		if (accept) begin
			line1_mem[col_q] <= pixel_in;
			line2_mem[col_q] <= rd1_q;
			rd1_q <= line1_mem[next_col];
			rd2_q <= line2_mem[next_col];
		end
	end

	// West neighbor and the last two pixels of the current row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec0_q <= '0;
			rec1_q <= '0;
		end else if (accept) begin
			rec0_q <= pixel_in;
			rec1_q <= rec0_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_q <= rd1_q;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 operands
	always_ff @(posedge clk) begin
		if (accept) begin
			ctr_s1      <= rd1_q;
			north_s1    <= (row_q >= RowW'(2)) ? rd2_q : pixel_in;
			west_s1     <= prev_q;
			px_s1       <= pixel_in;
			rec0_s1     <= rec0_q;
			rec1_s1     <= rec1_q;
			row_s1      <= row_q;
			col_s1      <= col_q;
			has_up_s1   <= (row_q != '0);
			has_w_s1    <= (col_q != '0);
			has_ww_s1   <= (col_q >= ColW'(2));
			has_e_s1    <= !at_last_col;
			last_row_s1 <= at_last_row;
			last_col_s1 <= at_last_col;
		end
	end

	// East neighbor arrives from the prefetch of this pixel
	assign east = rd1_q;

	// Mirror at the left and right borders
	assign a_w = has_w_s1 ? west_s1 : east;
	assign a_e = has_e_s1 ? east : west_s1;
	assign b_w = has_ww_s1 ? rec1_s1 : px_s1;

	// Result for the row above
	assign res_a.pixel_out = diffuse(ctr_s1, north_s1, px_s1, a_e, a_w);
	assign res_a.out_row   = PosW'(row_s1 - RowW'(1));
	assign res_a.out_col   = PosW'(col_s1);
	assign res_a.run_last  = !(do_b || do_c);

	// Last row: pixel to the left of the current one
	assign do_b            = last_row_s1 && has_w_s1;
	assign res_b.pixel_out = diffuse(rec0_s1, west_s1, west_s1, px_s1, b_w);
	assign res_b.out_row   = PosW'(row_s1);
	assign res_b.out_col   = PosW'(col_s1 - ColW'(1));
	assign res_b.run_last  = !do_c;

	// Last row, last column: the current pixel itself
	assign do_c            = last_row_s1 && last_col_s1;
	assign res_c.pixel_out = diffuse(px_s1, ctr_s1, ctr_s1, rec0_s1, rec0_s1);
	assign res_c.out_row   = PosW'(row_s1);
	assign res_c.out_col   = PosW'(col_s1);
	assign res_c.run_last  = 1'b1;

	// Pack in output order
	always_comb begin
		bundle.count   = '0;
		bundle.slot[0] = res_a;
		bundle.slot[1] = do_b ? res_b : res_c;
		bundle.slot[2] = res_c;
		if (valid_s1 && has_up_s1) begin
			bundle.count = 2'd1 + 2'(do_b) + 2'(do_c);
		end
	end

endmodule

>>> hw/rtl/hds_outq.sv
// Result queue: takes up to three results a cycle, hands out one while the output is ready.
// Depends on hds_pkg.
module hds_outq import hds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  res_bundle_t bundle,
	output logic        room,
	output logic        out_valid,
	input  logic        out_ready,
	output res_t        out_res
);

	res_t             fifo_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             pop;

	assign out_valid = (count_q != '0);
	assign out_res   = fifo_q[rd_ptr_q];
	assign pop       = out_valid & out_ready;

	// One more pixel may enter if its results fit after the pending ones
	assign room = (count_q + QCntW'(bundle.count)) <= QCntW'(QDepth - MaxRes);

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPtrW'(bundle.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			count_q <= count_q + QCntW'(bundle.count) - QCntW'(pop);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < MaxRes; i++) begin
			if (2'(i) < bundle.count) begin
				fifo_q[QPtrW'(wr_ptr_q + QPtrW'(i))] <= bundle.slot[i];
			end
		end
	end

endmodule

>>> hw/rtl/heat_diffusion_stencil_top.sv
// Top level of the heat diffusion stencil: register block, stencil
// datapath and result queue. Depends on hds_pkg, hds_if, hds_cfg,
// hds_stencil and hds_outq.
//
//  channel  dir  handshake       payload
//  pix      in   valid/ready     pixel_in[7:0]
//  res      out  valid/ready     pixel_out[7:0] out_row[9:0] out_col[9:0] run_last
//  apb      in   psel/penable    paddr[2:0] pwdata[31:0] prdata[31:0] (pready high)
//
// One pixel is accepted per clock while ready is high; the line memories read the
// next column and write the current one in the same cycle. Results are registered
// and leave the queue one per clock while the output is ready; last-row pixels (up
// to three results each) are paced by the output port. An 8-entry result queue
// absorbs output stalls; input ready drops only when it cannot hold three more
// results. Reset is asynchronous, active low; the line memories need no clearing.
module heat_diffusion_stencil_top import hds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	hds_pix_if.sink          pix,
	hds_res_if.source        res,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready
);

	cfg_ctl_t    ctl;
	res_bundle_t bundle;
	res_t        out_res;
	logic        room;
	logic        accept;

	assign pix.ready = room;
	assign accept    = pix.valid & room;

	hds_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ctl     (ctl)
	);

	hds_stencil u_stencil (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.accept   (accept),
		.pixel_in (pix.pixel_in),
		.bundle   (bundle)
	);

	hds_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.room      (room),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_res   (out_res)
	);

	assign res.pixel_out = out_res.pixel_out;
	assign res.out_row   = out_res.out_row;
	assign res.out_col   = out_res.out_col;
	assign res.run_last  = out_res.run_last;

endmodule

>>> hw/rtl/hds_check.sv
// Port-level checks for the heat diffusion stencil, bound to the top.
// Depends on hds_pkg and hds_if.
module hds_check import hds_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	hds_pix_if.sink pix,
	hds_res_if.source res,
	input logic  pready
);

	// Register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	// An empty result queue always takes a pixel
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> pix.ready)
		else $error("input stalled with no result pending");

	// A result appears only after the pixel that caused it was accepted
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(pix.valid && pix.ready, 2))
		else $error("result without a matching pixel");

	// A stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.pixel_out))
		else $error("stalled result dropped or changed");

endmodule

bind heat_diffusion_stencil_top hds_check u_check (
	.clk    (clk),
	.arst_n (arst_n),
	.pix    (pix),
	.res    (res),
	.pready (pready)
);
